>>> rtl/paired_comparison_counter_macros.svh
// Assertion macros shared by the paired comparison counter modules.
`ifndef PAIRED_COMPARISON_COUNTER_MACROS_SVH
`define PAIRED_COMPARISON_COUNTER_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define PCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante.
`define PCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pcc_pkg.sv
// Package with the types, constants and helpers of the paired comparison counter.
package pcc_pkg;

	localparam int MAX_ITEMS  = 16;
	localparam int COUNT_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_ITEMS);
	localparam int K_W        = $clog2(MAX_ITEMS + 1);
	localparam int CODE_W     = 5;
	localparam int REQ_W      = 2;
	localparam int RC_W       = 4;
	localparam int OUT_W      = 32;
	localparam int CFG_W      = 5;
	localparam int WIDE_W     = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

	localparam logic [REQ_W-1:0] REQ_ENTRY = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	typedef logic [MAX_ITEMS-1:0]  mask_t;
	typedef logic [COUNT_BITS-1:0] counter_t;
	typedef counter_t [MAX_ITEMS-1:0] row_t;
	typedef logic [IDX_W-1:0]      idx_t;

	localparam counter_t COUNT_MAX = '1;

	// Update request for one matrix row, produced when a slot entry is taken.
	typedef struct packed {
		logic  upd;
		idx_t  row;
		mask_t incr;
	} entry_t;

	// Limits a counter to the width of the count output.
	function automatic logic [OUT_W-1:0] clip_count(counter_t c);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(c);
		if (w > WIDE_W'({OUT_W{1'b1}}))
			return '1;
		return w[OUT_W-1:0];
	endfunction

endpackage

>>> rtl/pcc_ranking.sv
// Ranking tracker: item count register, unplaced mask and slot position.
`include "paired_comparison_counter_macros.svh"

module pcc_ranking
	import pcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              take,
	input  logic              clear,
	input  logic [CODE_W-1:0] item_code,
	output entry_t            entry
);

	localparam int CMP_W = (CODE_W > K_W) ? CODE_W : K_W;

	logic [K_W-1:0] k_q;
	mask_t          mask_q;
	idx_t           slot_q;

	logic           is_last;
	logic           code_ok;
	idx_t           row;
	mask_t          use_mask;
	mask_t          next_mask;
	logic           upd;

	always_comb begin
		is_last   = K_W'(slot_q) >= (k_q - K_W'(1));
		code_ok   = (item_code != '0) && (CMP_W'(item_code) <= CMP_W'(k_q));
		row       = IDX_W'(CODE_W'(item_code - CODE_W'(1)));
		upd       = take && !is_last && code_ok;
		for (int k = 0; k < MAX_ITEMS; k++) begin
			use_mask[k] = K_W'(k) < k_q;
		end
		next_mask = upd ? (mask_q & ~(mask_t'(1) << row)) : mask_q;
		entry.upd  = upd;
		entry.row  = row;
		entry.incr = next_mask & use_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= K_W'(MAX_ITEMS);
		end else if (cfg_we) begin
			if (cfg_data < CFG_W'(2))
				k_q <= K_W'(2);
			else if (32'(cfg_data) > 32'(MAX_ITEMS))
				k_q <= K_W'(MAX_ITEMS);
			else
				k_q <= K_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '1;
			slot_q <= '0;
		end else if (clear || (take && is_last)) begin
			mask_q <= '1;
			slot_q <= '0;
		end else if (take) begin
			mask_q <= next_mask;
			slot_q <= IDX_W'(slot_q + 1'b1);
		end
	end

	// Every placed item used up one slot, so cleared bits never outnumber slots.
	`PCC_ASSERT_NOW(a_placed_le_slot, 1'b1, $countones(~mask_q) <= 32'(slot_q), "mask/slot mismatch")
	`PCC_ASSERT_NEXT(a_clear_restarts, clear, (mask_q == '1) && (slot_q == '0), "clear missed")

endmodule

>>> rtl/pcc_count_mem.sv
// Row-wide counter memory with per-row valid bits and write-to-read bypass.
`include "paired_comparison_counter_macros.svh"

module pcc_count_mem
	import pcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  idx_t rd_row,
	input  logic wr_en,
	input  idx_t wr_row,
	input  row_t wr_data,
	input  logic clear,
	output row_t rd_data
);

	row_t  mem [MAX_ITEMS];
	mask_t row_valid_q;
	row_t  rd_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_row] <= wr_data;
	end

	// A row written in this cycle is taken from the write port, and a row
	// not written since the last clear reads as all zero.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_row == rd_row))
				rd_q <= wr_data;
			else if (!row_valid_q[rd_row])
				rd_q <= '0;
			else
				rd_q <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (clear) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_row] <= 1'b1;
		end
	end

	assign rd_data = rd_q;

	`PCC_ASSERT_NEXT(a_bypass, rd_en && wr_en && (wr_row == rd_row), rd_q == $past(wr_data), "bypass lost")

endmodule

>>> rtl/pcc_row_update.sv
// Saturating increment of the selected counters of one matrix row.
module pcc_row_update
	import pcc_pkg::*;
(
	input  row_t  cur,
	input  mask_t incr,
	output row_t  nxt
);

	always_comb begin
		for (int k = 0; k < MAX_ITEMS; k++) begin
			if (incr[k] && (cur[k] != COUNT_MAX))
				nxt[k] = COUNT_BITS'(cur[k] + 1'b1);
			else
				nxt[k] = cur[k];
		end
	end

endmodule

>>> rtl/paired_comparison_counter.sv
// Paired comparison counter top level: request stage, row update and read output register.
//
// The block takes one request in every cycle unless in_stall holds it back. A slot entry reads its item's matrix row
// from a row-wide memory with one read and one write port as it is accepted, increments
// the counters of the still unplaced items in the next cycle and writes the row back; a
// bypass from the write port covers an entry or read of the same row in the following
// cycle. A read request delivers its count after acceptance through the memory read
// register and then an output register; input stalls only while a read result waits in
// that register and another read is behind it.
// Reset and clear requests take effect at once through per-row valid bits, so there is no
// clearing pass and the block is ready in the first cycle after reset.
`include "paired_comparison_counter_macros.svh"

module paired_comparison_counter
	import pcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [CODE_W-1:0] item_code,
	input  logic [RC_W-1:0]   read_row,
	input  logic [RC_W-1:0]   read_col,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [OUT_W-1:0]  count
);

	logic       in_accept;
	logic       take;
	logic       clear;
	logic       read_acc;
	logic       read_oob;
	entry_t     entry;
	logic       rd_en;
	idx_t       rd_row;
	row_t       rd_data;
	row_t       nxt_row;
	logic       s1_go;

	logic       wr_s1;
	logic       rd_s1;
	idx_t       row_s1;
	mask_t      incr_s1;
	idx_t       col_s1;
	logic       oob_s1;

	logic       out_valid_q;
	logic [OUT_W-1:0] count_q;

	assign in_accept = in_valid && !in_stall;
	assign take      = in_accept && (req_type == REQ_ENTRY);
	assign clear     = in_accept && (req_type == REQ_CLEAR);
	assign read_acc  = in_accept && (req_type == REQ_READ);
	assign read_oob  = (32'(read_row) >= 32'(MAX_ITEMS)) || (32'(read_col) >= 32'(MAX_ITEMS));

	assign rd_en  = entry.upd || read_acc;
	assign rd_row = entry.upd ? entry.row : IDX_W'(read_row);

	assign s1_go    = !out_valid_q || !out_stall;
	assign in_stall = rd_s1 && !s1_go;

	pcc_ranking u_ranking (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.take      (take),
		.clear     (clear),
		.item_code (item_code),
		.entry     (entry)
	);

	pcc_count_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.wr_en   (wr_s1),
		.wr_row  (row_s1),
		.wr_data (nxt_row),
		.clear   (clear),
		.rd_data (rd_data)
	);

	pcc_row_update u_update (
		.cur  (rd_data),
		.incr (incr_s1),
		.nxt  (nxt_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			rd_s1 <= 1'b0;
		end else begin
			wr_s1 <= entry.upd;
			if (in_accept)
				rd_s1 <= read_acc;
			else if (s1_go)
				rd_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			row_s1  <= entry.row;
			incr_s1 <= entry.incr;
			col_s1  <= IDX_W'(read_col);
			oob_s1  <= read_oob;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_s1 && s1_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1 && s1_go)
			count_q <= oob_s1 ? '0 : clip_count(rd_data[col_s1]);
	end

	assign out_valid = out_valid_q;
	assign count     = count_q;

	// Only a waiting read can hold back the input side.
	`PCC_ASSERT_NOW(a_stall_cause, in_stall, rd_s1 && out_valid_q, "stall without pending read")
	`PCC_ASSERT_NEXT(a_read_delivered, rd_s1 && s1_go, out_valid_q, "read transfer lost")
	`PCC_ASSERT_NOW(a_one_op_s1, 1'b1, !(wr_s1 && rd_s1), "write and read both in stage one")

endmodule
